/* rtl/core/klhr_pkg.sv */
// klhr_pkg: shared types and constants for the keymap layer hid report encoder
// no dependencies; imported by the interfaces, controller, datapath and checker

package klhr_pkg;

  // field widths fixed by the item and report formats
  localparam int OP_W        = 1;
  localparam int LAYER_FLD_W = 3;
  localparam int POS_FLD_W   = 6;
  localparam int WORD_W      = 16;
  localparam int MASK_W      = 18;
  localparam int CODE_W      = 8;
  localparam int COUNT_W     = 3;
  localparam int OUT_SLOTS   = 6;

  // keymap geometry
  localparam int HALF_COLS  = 5;
  localparam int ROW_STRIDE = 10;

  // operations
  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_SCAN = 1'b1;

  // keymap word kinds (high byte)
  localparam logic [CODE_W-1:0] KIND_LAYER    = 8'h10;
  localparam logic [CODE_W-1:0] KIND_MODIFIER = 8'h20;

  typedef logic [CODE_W-1:0] code_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic scan_start;
    logic key_step;
    logic list_step;
    logic publish;
  } klhr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic keys_last;
    logic list_more;
    logic busy;
    logic out_free;
  } klhr_sts_t;

endpackage

/* rtl/core/klhr_in_if.sv */
// klhr_in_if: input item channel (load or scan) with valid/ready handshake
// depends on klhr_pkg for field widths

interface klhr_in_if;
  import klhr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [LAYER_FLD_W-1:0] layer;
  logic [POS_FLD_W-1:0]   position;
  logic [WORD_W-1:0]      entry_value;
  logic [MASK_W-1:0]      primary_keys;
  logic [MASK_W-1:0]      secondary_keys;

  modport source (output valid, output operation, output layer, output position,
                  output entry_value, output primary_keys, output secondary_keys,
                  input ready);
  modport sink   (input valid, input operation, input layer, input position,
                  input entry_value, input primary_keys, input secondary_keys,
                  output ready);
endinterface

/* rtl/core/klhr_out_if.sv */
// klhr_out_if: hid report channel with valid/ready handshake
// depends on klhr_pkg for field widths

interface klhr_out_if;
  import klhr_pkg::*;

  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  modifier_bits;
  logic [CODE_W-1:0]  code_0;
  logic [CODE_W-1:0]  code_1;
  logic [CODE_W-1:0]  code_2;
  logic [CODE_W-1:0]  code_3;
  logic [CODE_W-1:0]  code_4;
  logic [CODE_W-1:0]  code_5;
  logic [COUNT_W-1:0] code_count;
  logic               keys_dropped;

  modport source (output valid, output modifier_bits, output code_0, output code_1,
                  output code_2, output code_3, output code_4, output code_5,
                  output code_count, output keys_dropped, input ready);
  modport sink   (input valid, input modifier_bits, input code_0, input code_1,
                  input code_2, input code_3, input code_4, input code_5,
                  input code_count, input keys_dropped, output ready);
endinterface

/* rtl/core/klhr_ctrl.sv */
// klhr_ctrl: sequencing state machine for loads and scans
// depends on klhr_pkg; drives klhr_datapath through command/status structs

module klhr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [klhr_pkg::OP_W-1:0] in_operation,
  output logic                      in_ready,
  output klhr_pkg::klhr_cmd_t       cmd,
  input  klhr_pkg::klhr_sts_t       sts
);
  import klhr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_KEYS   = 3'd1;
  localparam logic [2:0] S_KDRAIN = 3'd2;
  localparam logic [2:0] S_LIST   = 3'd3;
  localparam logic [2:0] S_LDRAIN = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == OP_SCAN) begin
            cmd.scan_start = 1'b1;
            state_next     = S_KEYS;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_KEYS: begin
        cmd.key_step = 1'b1;
        if (sts.keys_last) state_next = S_KDRAIN;
      end
      S_KDRAIN: begin
        // last layer-0 word still being evaluated
        if (!sts.busy) state_next = S_LIST;
      end
      S_LIST: begin
        if (sts.list_more) begin
          cmd.list_step = 1'b1;
        end else begin
          state_next = S_LDRAIN;
        end
      end
      S_LDRAIN: begin
        if (!sts.busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/klhr_datapath.sv */
// klhr_datapath: keymap memory, key walk, pressed list, report build and output register
// depends on klhr_pkg; sequenced by klhr_ctrl

module klhr_datapath #(
  parameter int NUM_LAYERS    = 6,
  parameter int KEYS_PER_SIDE = 18,
  parameter int MAX_PRESSED   = 10,
  parameter int REPORT_SLOTS  = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  klhr_pkg::klhr_cmd_t                    cmd,
  output klhr_pkg::klhr_sts_t                    sts,
  input  logic [klhr_pkg::LAYER_FLD_W-1:0]       load_layer,
  input  logic [klhr_pkg::POS_FLD_W-1:0]         load_position,
  input  logic [klhr_pkg::WORD_W-1:0]            load_value,
  input  logic [klhr_pkg::MASK_W-1:0]            primary_keys,
  input  logic [klhr_pkg::MASK_W-1:0]            secondary_keys,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [klhr_pkg::CODE_W-1:0]            out_mods,
  output klhr_pkg::code_t [klhr_pkg::OUT_SLOTS-1:0] out_codes,
  output logic [klhr_pkg::COUNT_W-1:0]           out_count,
  output logic                                   out_dropped
);
  import klhr_pkg::*;

  localparam int KEY_ROWS      = (KEYS_PER_SIDE + HALF_COLS - 1) / HALF_COLS;
  localparam int KEY_POSITIONS = KEY_ROWS * ROW_STRIDE;
  localparam int DEPTH         = NUM_LAYERS * KEY_POSITIONS;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int POS_W         = $clog2(KEY_POSITIONS);
  localparam int LAYER_W       = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int KEY_W         = (KEYS_PER_SIDE > 1) ? $clog2(KEYS_PER_SIDE) : 1;
  localparam int LIST_W        = $clog2(MAX_PRESSED + 1);
  localparam int LIST_IDX_W    = (MAX_PRESSED > 1) ? $clog2(MAX_PRESSED) : 1;
  localparam int CAPACITY      = (REPORT_SLOTS < OUT_SLOTS) ? REPORT_SLOTS : OUT_SLOTS;

  // keymap memory, single write and single registered read
  logic [WORD_W-1:0] keymap [DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  // key walk
  logic [KEYS_PER_SIDE-1:0] mask_p;
  logic [KEYS_PER_SIDE-1:0] mask_s;
  logic                     half;
  logic [KEY_W-1:0]         key;
  logic [2:0]               col;
  logic [POS_W-1:0]         pos;
  logic                     key_hit;

  // pressed list
  logic [POS_W-1:0]  listed [MAX_PRESSED];
  logic [LIST_W-1:0] nlisted;
  logic [LIST_W-1:0] li;
  logic [POS_W-1:0]  list_q;
  logic [LAYER_W-1:0] active;

  // pipeline valids: layer-0 read, list read, active-layer read
  logic p1_valid;
  logic p2_valid;
  logic p3_valid;
  logic [POS_W-1:0] p1_pos;

  // report under construction
  logic [CODE_W-1:0]                 mods;
  code_t [OUT_SLOTS-1:0]             codes;
  logic [COUNT_W-1:0]                ncodes;
  logic                              dropped;

  logic [CODE_W-1:0] hi;
  logic [CODE_W-1:0] lo;

  assign hi = rd_data[WORD_W-1:CODE_W];
  assign lo = rd_data[CODE_W-1:0];

  assign wr_en   = cmd.load_wr && (load_layer < NUM_LAYERS) && (load_position < KEY_POSITIONS);
  assign wr_addr = ADDR_W'(32'(load_layer) * KEY_POSITIONS + 32'(load_position));
  assign rd_addr = p2_valid ? ADDR_W'(32'(active) * KEY_POSITIONS + 32'(list_q))
                            : ADDR_W'(pos);

  assign key_hit = half ? mask_s[key] : mask_p[key];

  assign sts.keys_last = half && (key == KEY_W'(KEYS_PER_SIDE - 1));
  assign sts.list_more = li < nlisted;
  assign sts.busy      = p1_valid || p2_valid || p3_valid;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) keymap[wr_addr] <= load_value;
    rd_data <= keymap[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.key_step && key_hit;
      p2_valid <= cmd.list_step;
      p3_valid <= p2_valid;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      mask_p  <= KEYS_PER_SIDE'(primary_keys);
      mask_s  <= KEYS_PER_SIDE'(secondary_keys);
      half    <= 1'b0;
      key     <= '0;
      col     <= '0;
      pos     <= '0;
      active  <= '0;
      nlisted <= '0;
      li      <= '0;
      mods    <= '0;
      codes   <= '0;
      ncodes  <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.key_step) begin
        p1_pos <= pos;
        if (key == KEY_W'(KEYS_PER_SIDE - 1)) begin
          // on to the secondary half, whose columns start at five
          half <= 1'b1;
          key  <= '0;
          col  <= '0;
          pos  <= POS_W'(HALF_COLS);
        end else if (col == 3'(HALF_COLS - 1)) begin
          key <= key + 1'b1;
          col <= '0;
          pos <= pos + POS_W'(ROW_STRIDE - HALF_COLS + 1);
        end else begin
          key <= key + 1'b1;
          col <= col + 1'b1;
          pos <= pos + 1'b1;
        end
      end

      // layer-0 word of a pressed key
      if (p1_valid) begin
        if (hi == KIND_LAYER) begin
          if (lo < NUM_LAYERS) active <= LAYER_W'(lo);
        end else if (nlisted < LIST_W'(MAX_PRESSED)) begin
          listed[nlisted[LIST_IDX_W-1:0]] <= p1_pos;
          nlisted <= nlisted + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end

      if (cmd.list_step) begin
        list_q <= listed[li[LIST_IDX_W-1:0]];
        li     <= li + 1'b1;
      end

      // active-layer word of a listed key
      if (p3_valid) begin
        if (hi == KIND_MODIFIER) begin
          mods <= mods | lo;
        end else begin
          mods <= mods | hi;
          if (ncodes < COUNT_W'(CAPACITY)) begin
            codes[ncodes] <= lo;
            ncodes        <= ncodes + 1'b1;
          end else begin
            dropped <= 1'b1;
          end
        end
      end
    end

    if (cmd.publish) begin
      out_mods    <= mods;
      out_codes   <= codes;
      out_count   <= ncodes;
      out_dropped <= dropped;
    end
  end

endmodule

/* rtl/core/keymap_layer_hid_report.sv */
// keymap_layer_hid_report: top level of the split-keyboard keymap to hid boot report encoder
// depends on klhr_pkg, klhr_in_if, klhr_out_if, klhr_ctrl and klhr_datapath

// A load beat writes one 16-bit keymap word (layer, position) and gives no report;
// loads outside the table are ignored. A scan beat walks the primary half's keys and
// then the secondary half's, one key per cycle through the single read port of the
// keymap memory, then reads the active-layer word of each listed key, again one a
// cycle. At most MAX_PRESSED keys are listed. The input is not ready during a scan.
// Loads and scans are both taken while a finished report waits in the output
// register, but a new scan's report is held back, with the input still not ready,
// until that report is taken. Every keymap entry a scan reaches must have been
// loaded first: the memory is not cleared at reset.

module keymap_layer_hid_report #(
  parameter int NUM_LAYERS    = 6,
  parameter int KEYS_PER_SIDE = 18,
  parameter int MAX_PRESSED   = 10,
  parameter int REPORT_SLOTS  = 6
) (
  input logic        clk,
  input logic        rst,
  klhr_in_if.sink    item,
  klhr_out_if.source report
);
  import klhr_pkg::*;

  klhr_cmd_t             cmd;
  klhr_sts_t             sts;
  code_t [OUT_SLOTS-1:0] out_codes;

  klhr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (item.valid),
    .in_operation (item.operation),
    .in_ready     (item.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  klhr_datapath #(
    .NUM_LAYERS    (NUM_LAYERS),
    .KEYS_PER_SIDE (KEYS_PER_SIDE),
    .MAX_PRESSED   (MAX_PRESSED),
    .REPORT_SLOTS  (REPORT_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .load_layer     (item.layer),
    .load_position  (item.position),
    .load_value     (item.entry_value),
    .primary_keys   (item.primary_keys),
    .secondary_keys (item.secondary_keys),
    .out_ready      (report.ready),
    .out_valid      (report.valid),
    .out_mods       (report.modifier_bits),
    .out_codes      (out_codes),
    .out_count      (report.code_count),
    .out_dropped    (report.keys_dropped)
  );

  assign report.code_0 = out_codes[0];
  assign report.code_1 = out_codes[1];
  assign report.code_2 = out_codes[2];
  assign report.code_3 = out_codes[3];
  assign report.code_4 = out_codes[4];
  assign report.code_5 = out_codes[5];

endmodule

/* rtl/core/klhr_checker.sv */
// klhr_checker: port-level assertions for keymap_layer_hid_report, bound to the top level
// depends on klhr_pkg

module klhr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [klhr_pkg::OP_W-1:0]     item_operation,
  input logic                          report_valid,
  input logic                          report_ready,
  input logic [klhr_pkg::CODE_W-1:0]   modifier_bits,
  input logic [klhr_pkg::CODE_W-1:0]   code_0,
  input logic [klhr_pkg::CODE_W-1:0]   code_1,
  input logic [klhr_pkg::CODE_W-1:0]   code_2,
  input logic [klhr_pkg::CODE_W-1:0]   code_3,
  input logic [klhr_pkg::CODE_W-1:0]   code_4,
  input logic [klhr_pkg::CODE_W-1:0]   code_5,
  input logic [klhr_pkg::COUNT_W-1:0]  code_count,
  input logic                          keys_dropped
);
  import klhr_pkg::*;

  // count never exceeds the six report slots
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> code_count <= 3'd6)
    else $error("code_count above six");

  // slots past the count are zero
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> ((code_count > 3'd0 || code_0 == '0) &&
                      (code_count > 3'd1 || code_1 == '0) &&
                      (code_count > 3'd2 || code_2 == '0) &&
                      (code_count > 3'd3 || code_3 == '0) &&
                      (code_count > 3'd4 || code_4 == '0) &&
                      (code_count > 3'd5 || code_5 == '0)))
    else $error("unused report slot not zero");

  // a stalled report holds
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid &&
      $stable({modifier_bits, code_0, code_1, code_2, code_3, code_4, code_5,
               code_count, keys_dropped}))
    else $error("report changed while stalled");

  // input only stalls after a scan beat
  a_busy_after_scan: assert property (@(posedge clk) disable iff (rst)
    $fell(item_ready) |-> $past(item_valid && item_operation == OP_SCAN))
    else $error("input stalled without a scan");

  // a new report only appears at the end of a scan
  a_report_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |-> $past(!item_ready))
    else $error("report raised outside a scan");

endmodule

bind keymap_layer_hid_report klhr_checker u_klhr_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .item_operation (item.operation),
  .report_valid   (report.valid),
  .report_ready   (report.ready),
  .modifier_bits  (report.modifier_bits),
  .code_0         (report.code_0),
  .code_1         (report.code_1),
  .code_2         (report.code_2),
  .code_3         (report.code_3),
  .code_4         (report.code_4),
  .code_5         (report.code_5),
  .code_count     (report.code_count),
  .keys_dropped   (report.keys_dropped)
);
